FILE: sv/yfi_pkg.sv
// shared types, constants and codes for the yuv frame to i420 converter
`timescale 1ns / 1ps
package yfi_pkg;

  // fixed field widths
  localparam int ADDR_W  = 25;
  localparam int BYTE_W  = 8;
  localparam int PLANE_W = 2;
  localparam int FMT_W   = 2;
  localparam int DIM_W   = 13;
  localparam int INDEX_W = 2;
  localparam int ROW_W   = 13;

  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // register reset values
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // decoupling queue depth, power of two
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [FMT_W-1:0] {
    FMT_I420   = 2'd0,
    FMT_YVU420 = 2'd1,
    FMT_YUYV   = 2'd2,
    FMT_UYVY   = 2'd3
  } src_format_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_t;

  // constant that the back end applies to the relative address
  typedef enum logic [2:0] {
    OFS_NONE    = 3'd0,
    OFS_PLUS_Q  = 3'd1,
    OFS_MINUS_Q = 3'd2,
    OFS_PLUS_Y  = 3'd3,
    OFS_PLUS_YQ = 3'd4
  } offset_sel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] source_byte;
    logic              end_of_frame;
  } pixel_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_address;
    logic [BYTE_W-1:0]  byte_value;
    logic [PLANE_W-1:0] plane;
  } i420_write_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIM_W-1:0]   value;
  } cfg_write_t;

  // classified write waiting for address completion
  typedef struct packed {
    offset_sel_t       sel;
    logic [ADDR_W-1:0] rel;
    logic [BYTE_W-1:0] byte_value;
    plane_t            plane;
  } write_op_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: sv/yfi_chan_if.sv
// valid/ready channel carrying one item of a given payload type
`timescale 1ns / 1ps
interface yfi_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/yuv_frame_to_i420_converter_top.sv
// top level of the camera frame to i420 planar converter
`timescale 1ns / 1ps
// Usage:
//   pixel_in takes the source frame one byte per item in buffer order, with
//   end_of_frame set on the last byte; position counters then return to zero.
//   i420_out gives zero or one write per byte: destination offset, byte and
//   plane (0 luma, 1 Cb, 2 Cr). cfg writes the source format (index 0), the
//   width in pixels (index 1) and the height in rows (index 2); cfg.ready is
//   always high.
//   Throughput is one byte per cycle while pixel_in.ready is high. A write
//   passes from the accepted byte through a queue slot and then the output
//   register in the back end before it is presented on i420_out.
//   The front end classifies bytes and keeps the frame position; a four-entry
//   queue separates it from the back end, which finishes the address.
//   After reset and after every cfg write, pixel_in.ready stays low while
//   the plane size products and region bounds are recomputed.
//   Reset loads format 3 (UYVY), width 640, height 480 and clears the position.
//   When i420_out stalls, the output item holds, the queue fills, and
//   pixel_in.ready drops once four writes wait in the queue.
module yuv_frame_to_i420_converter_top #(
  parameter int MAX_WIDTH  = yfi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yfi_pkg::MAX_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst,
  yfi_chan_if.sink   pixel_in,
  yfi_chan_if.source i420_out,
  yfi_chan_if.sink   cfg
);
  import yfi_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int YW = WW + HW;
  localparam int SW = YW + 1;

  src_format_t   fmt;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] kept_rows;
  logic [YW-1:0] y_size;
  logic [YW-1:0] q_size;
  logic [SW-1:0] yq_end;
  logic [SW-1:0] yqq_end;
  logic [SW-1:0] wk_end;
  logic [SW-1:0] yck_end;
  logic [SW-1:0] yqck_end;
  logic          settled;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  write_op_t     q_entry;
  write_op_t     q_head;

  // configuration and geometry
  yfi_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fmt       (fmt),
    .w_eff     (w_eff),
    .kept_rows (kept_rows),
    .y_size    (y_size),
    .q_size    (q_size),
    .yq_end    (yq_end),
    .yqq_end   (yqq_end),
    .wk_end    (wk_end),
    .yck_end   (yck_end),
    .yqck_end  (yqck_end),
    .settled   (settled)
  );

  // classification front end
  yfi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .fmt       (fmt),
    .w_eff     (w_eff),
    .kept_rows (kept_rows),
    .y_size    (y_size),
    .yq_end    (yq_end),
    .yqq_end   (yqq_end),
    .wk_end    (wk_end),
    .yck_end   (yck_end),
    .yqck_end  (yqck_end),
    .settled   (settled),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decoupling queue
  yfi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // address completion and output register
  yfi_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_status (q_status),
    .y_size   (y_size),
    .q_size   (q_size),
    .yq_end   (yq_end),
    .pop      (q_pop),
    .i420_out (i420_out)
  );

  // a classified write never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("write pushed into full queue");

  // no byte is taken in the cycle after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> !(pixel_in.valid && pixel_in.ready))
    else $error("byte accepted before geometry settled");

  // a stalled output with a full queue blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (i420_out.valid && !i420_out.ready && q_status.full) |-> !pixel_in.ready)
    else $error("input ready while output path is full");

endmodule

FILE: sv/yfi_geom.sv
// configuration registers and derived frame geometry
`timescale 1ns / 1ps
module yfi_geom #(
  parameter int MAX_WIDTH  = yfi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yfi_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int YW = WW + HW,
  localparam int SW = YW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  yfi_chan_if.sink             cfg,
  output yfi_pkg::src_format_t fmt,
  output logic [WW-1:0]        w_eff,
  output logic [HW-1:0]        kept_rows,
  output logic [YW-1:0]        y_size,
  output logic [YW-1:0]        q_size,
  output logic [SW-1:0]        yq_end,
  output logic [SW-1:0]        yqq_end,
  output logic [SW-1:0]        wk_end,
  output logic [SW-1:0]        yck_end,
  output logic [SW-1:0]        yqck_end,
  output logic                 settled
);
  import yfi_pkg::*;

  localparam int CAP_W     = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int DWW       = (WW > DIM_W) ? WW : DIM_W;
  localparam int DHW       = (HW > DIM_W) ? HW : DIM_W;
  localparam int RST_W_RAW = WIDTH_RST - (WIDTH_RST % 2);
  localparam int RST_W     = (RST_W_RAW > CAP_W) ? CAP_W : RST_W_RAW;
  localparam int RST_H     = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  logic [HW-1:0]  h_eff;
  logic [YW-1:0]  ck_size;
  logic [1:0]     settle_cnt;
  logic           cfg_wr;
  logic [DWW-1:0] w_raw;
  logic [DWW-1:0] w_clip;
  logic [DHW-1:0] h_raw;
  logic [DHW-1:0] h_clip;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign kept_rows = {h_eff[HW-1:2], 2'b00};
  assign settled   = (settle_cnt == 2'd0);

  // clip written sizes to the supported range, width rounded down to even
  always_comb begin
    w_raw  = DWW'({cfg.data.value[DIM_W-1:1], 1'b0});
    w_clip = (w_raw > DWW'(CAP_W)) ? DWW'(CAP_W) : w_raw;
    h_raw  = DHW'(cfg.data.value);
    h_clip = (h_raw > DHW'(MAX_HEIGHT)) ? DHW'(MAX_HEIGHT) : h_raw;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt   <= FMT_UYVY;
      w_eff <= WW'(RST_W);
      h_eff <= HW'(RST_H);
    end else if (cfg_wr) begin
      case (cfg.data.index)
        REG_FORMAT: fmt   <= src_format_t'(cfg.data.value[FMT_W-1:0]);
        REG_WIDTH:  w_eff <= WW'(w_clip);
        REG_HEIGHT: h_eff <= HW'(h_clip);
        default: ;
      endcase
    end
  end

  // settle counter, reloaded on reset or a write, counts down until the geometry has settled
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= 2'd2;
    end else if (cfg_wr) begin
      settle_cnt <= 2'd2;
    end else if (settle_cnt != 2'd0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  // stage one: plane products
  always_ff @(posedge clk) begin
    y_size  <= YW'(w_eff) * YW'(h_eff);
    ck_size <= YW'(w_eff) * YW'(h_eff >> 2);
  end

  // stage two: region boundaries
  always_ff @(posedge clk) begin
    q_size   <= y_size >> 2;
    yq_end   <= SW'(y_size) + SW'(y_size >> 2);
    yqq_end  <= SW'(y_size) + (SW'(y_size >> 2) << 1);
    wk_end   <= SW'(ck_size) << 2;
    yck_end  <= SW'(y_size) + SW'(ck_size);
    yqck_end <= SW'(y_size) + SW'(y_size >> 2) + SW'(ck_size);
  end

endmodule

FILE: sv/yfi_front.sv
// front end: position tracking and classification of source bytes
`timescale 1ns / 1ps
module yfi_front #(
  parameter int MAX_WIDTH  = yfi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yfi_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int YW = WW + HW,
  localparam int SW = YW + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  yfi_chan_if.sink               pixel_in,
  input  yfi_pkg::src_format_t   fmt,
  input  logic [WW-1:0]          w_eff,
  input  logic [HW-1:0]          kept_rows,
  input  logic [YW-1:0]          y_size,
  input  logic [SW-1:0]          yq_end,
  input  logic [SW-1:0]          yqq_end,
  input  logic [SW-1:0]          wk_end,
  input  logic [SW-1:0]          yck_end,
  input  logic [SW-1:0]          yqck_end,
  input  logic                   settled,
  input  yfi_pkg::queue_status_t q_status,
  output logic                   q_push,
  output yfi_pkg::write_op_t     q_entry
);
  import yfi_pkg::*;

  localparam int CW  = (SW > ADDR_W) ? SW : ADDR_W;
  localparam int CCW = WW + 1;
  localparam int RCW = (HW > ROW_W) ? HW : ROW_W;

  logic [ADDR_W-1:0] byte_offset;
  logic [CCW-1:0]    column_count;
  logic [ROW_W-1:0]  row_count;
  logic [ADDR_W-1:0] luma_row_base;
  logic [ADDR_W-1:0] chroma_row_base;

  logic [CW-1:0]  p_x;
  logic           in_y;
  logic           in_yq;
  logic           in_yqq;
  logic           row_in;
  logic           col_in;
  logic [CCW-1:0] two_w;
  logic [CCW-1:0] col_inc;
  logic           is_luma;
  logic           emit;
  logic           accept;

  assign pixel_in.ready = settled && !q_status.full;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign q_push         = accept && emit;

  // region and window tests
  always_comb begin
    p_x     = CW'(byte_offset);
    in_y    = p_x < CW'(y_size);
    in_yq   = p_x < CW'(yq_end);
    in_yqq  = p_x < CW'(yqq_end);
    row_in  = RCW'(row_count) < RCW'(kept_rows);
    two_w   = {w_eff, 1'b0};
    col_in  = column_count < two_w;
    col_inc = column_count + CCW'(1);
    is_luma = (fmt == FMT_YUYV) ? !column_count[0] : column_count[0];
  end

  // classify the byte into a write or a drop
  always_comb begin
    emit               = 1'b0;
    q_entry.sel        = OFS_NONE;
    q_entry.rel        = byte_offset;
    q_entry.byte_value = pixel_in.data.source_byte;
    q_entry.plane      = PLANE_Y;
    case (fmt)
      FMT_I420: begin
        emit = 1'b1;
        if (in_y) begin
          q_entry.plane = PLANE_Y;
        end else if (in_yq) begin
          q_entry.plane = PLANE_CB;
        end else begin
          q_entry.plane = PLANE_CR;
        end
      end
      FMT_YVU420: begin
        if (p_x < CW'(wk_end)) begin
          emit = 1'b1;
        end else if (!in_y && in_yq && (p_x < CW'(yck_end))) begin
          emit          = 1'b1;
          q_entry.sel   = OFS_PLUS_Q;
          q_entry.plane = PLANE_CR;
        end else if (!in_yq && in_yqq && (p_x < CW'(yqck_end))) begin
          emit          = 1'b1;
          q_entry.sel   = OFS_MINUS_Q;
          q_entry.plane = PLANE_CB;
        end
      end
      FMT_YUYV, FMT_UYVY: begin
        if (row_in && col_in) begin
          if (is_luma) begin
            emit        = 1'b1;
            q_entry.rel = luma_row_base + ADDR_W'(column_count >> 1);
          end else if (!row_count[0]) begin
            // cb sits where bit 1 of the column is clear in both packings
            emit        = 1'b1;
            q_entry.rel = chroma_row_base + ADDR_W'(column_count >> 2);
            if (!column_count[1]) begin
              q_entry.sel   = OFS_PLUS_Y;
              q_entry.plane = PLANE_CB;
            end else begin
              q_entry.sel   = OFS_PLUS_YQ;
              q_entry.plane = PLANE_CR;
            end
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      column_count    <= '0;
      row_count       <= '0;
      luma_row_base   <= '0;
      chroma_row_base <= '0;
    end else if (accept) begin
      if (pixel_in.data.end_of_frame) begin
        byte_offset     <= '0;
        column_count    <= '0;
        row_count       <= '0;
        luma_row_base   <= '0;
        chroma_row_base <= '0;
      end else begin
        byte_offset <= byte_offset + ADDR_W'(1);
        if (col_inc >= two_w) begin
          column_count <= '0;
          if (row_count != ROW_SAT) begin
            luma_row_base <= luma_row_base + ADDR_W'(w_eff);
            if (row_count[0]) begin
              chroma_row_base <= chroma_row_base + ADDR_W'(w_eff >> 1);
            end
            row_count <= row_count + ROW_W'(1);
          end
        end else begin
          column_count <= col_inc;
        end
      end
    end
  end

endmodule

FILE: sv/yfi_queue.sv
// short queue of classified writes between front and back end
`timescale 1ns / 1ps
module yfi_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  yfi_pkg::write_op_t     push_entry,
  input  logic                   pop,
  output yfi_pkg::write_op_t     head,
  output yfi_pkg::queue_status_t status
);
  import yfi_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  write_op_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/yfi_back.sv
// back end: completes the destination address and holds the output item
`timescale 1ns / 1ps
module yfi_back #(
  parameter int MAX_WIDTH  = yfi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yfi_pkg::MAX_HEIGHT_DEF,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int YW = WW + HW,
  localparam int SW = YW + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  yfi_pkg::write_op_t     head,
  input  yfi_pkg::queue_status_t q_status,
  input  logic [YW-1:0]          y_size,
  input  logic [YW-1:0]          q_size,
  input  logic [SW-1:0]          yq_end,
  output logic                   pop,
  yfi_chan_if.source             i420_out
);
  import yfi_pkg::*;

  logic              out_valid;
  i420_write_t       out_data;
  logic              load;
  logic [ADDR_W-1:0] ofs;
  logic [ADDR_W-1:0] addr;

  assign load           = !out_valid || i420_out.ready;
  assign pop            = !q_status.empty && load;
  assign i420_out.valid = out_valid;
  assign i420_out.data  = out_data;

  // plane offset and final address, modulo the address width
  always_comb begin
    case (head.sel)
      OFS_NONE:    ofs = '0;
      OFS_PLUS_Q:  ofs = ADDR_W'(q_size);
      OFS_MINUS_Q: ofs = ADDR_W'(q_size);
      OFS_PLUS_Y:  ofs = ADDR_W'(y_size);
      OFS_PLUS_YQ: ofs = ADDR_W'(yq_end);
      default:     ofs = '0;
    endcase
    addr = (head.sel == OFS_MINUS_Q) ? (head.rel - ofs) : (head.rel + ofs);
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.dest_address <= addr;
      out_data.byte_value   <= head.byte_value;
      out_data.plane        <= head.plane;
    end
  end

endmodule
